// File: src/svpt_pkg.sv
// Shared types and constants for the space vector PWM timing block.
package svpt_pkg;

   localparam int VOLT_W = 16;   // alpha, beta and bus voltage width
   localparam int CNT_W  = 16;   // period register width
   localparam int OUT_W  = 15;   // compare count width
   localparam int CODE_W = 3;    // sector code width
   localparam int FRAC_W = 16;   // Q16.16 fraction bits
   localparam int E_W    = 36;   // signed Q20.16 volt expressions
   localparam int CX_W   = 33;   // clamped active-vector expressions
   localparam int N_W    = CX_W + CNT_W;   // expression times period
   localparam int Q_W    = 40;   // quotient bits out of every divider
   localparam int DEN3_W = CX_W + 1;       // sum of both clamped expressions
   localparam int T_W    = 32;   // Q16.16 time within one period
   localparam int NUM1_W = Q_W + VOLT_W;
   localparam int NUM3_W = Q_W + DEN3_W;

   localparam logic signed [E_W-1:0] K_1P5   = 36'sd98304;
   localparam logic signed [E_W-1:0] K_0P866 = 36'sd56756;
   localparam logic signed [E_W-1:0] K_SQRT3 = 36'sd113512;

   localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd1000;

   typedef logic [CODE_W-1:0] sector_type;

   localparam sector_type SECTOR_ZERO = 3'd0;
   localparam sector_type SECTOR_1    = 3'd1;
   localparam sector_type SECTOR_2    = 3'd2;
   localparam sector_type SECTOR_3    = 3'd3;
   localparam sector_type SECTOR_4    = 3'd4;
   localparam sector_type SECTOR_5    = 3'd5;
   localparam sector_type SECTOR_6    = 3'd6;

   // side data that rides alongside the dividers
   typedef struct packed {
      sector_type code;
      logic       ovf_x;
      logic       ovf_y;
      logic       den_zero;
   } svpt_tag_type;

endpackage

// File: src/svpt_if.sv
// Request and response channel interfaces.
interface svpt_req_if import svpt_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [VOLT_W-1:0] alpha_voltage;
   logic signed [VOLT_W-1:0] beta_voltage;
   logic        [VOLT_W-1:0] bus_voltage;

   modport source (output valid, alpha_voltage, beta_voltage, bus_voltage, input ready);
   modport sink   (input valid, alpha_voltage, beta_voltage, bus_voltage, output ready);
endinterface

interface svpt_rsp_if import svpt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] phase_a_count;
   logic [OUT_W-1:0] phase_b_count;
   logic [OUT_W-1:0] phase_c_count;
   sector_type       sector_code;

   modport source (output valid, phase_a_count, phase_b_count, phase_c_count, sector_code,
                   input ready);
   modport sink   (input valid, phase_a_count, phase_b_count, phase_c_count, sector_code,
                   output ready);
endinterface

// File: src/svpt_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
module svpt_div_pipe import svpt_pkg::*; #(
   parameter int DEN_W = 16,
   parameter int QUO_W = 40
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [QUO_W+DEN_W-1:0] num,
   input  logic [DEN_W-1:0]       den,
   output logic [QUO_W-1:0]       quot
);

   logic [DEN_W-1:0] rem_ff [QUO_W-1];
   logic [QUO_W-1:0] lo_ff  [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [DEN_W-1:0] rem_s;
      logic [QUO_W-1:0] lo_s;
      logic [DEN_W-1:0] den_s;
      logic [QUO_W-1:0] quo_s;
      logic [DEN_W:0]   trial;
      logic             ge;

      // stage inputs: the operands for the first, the previous stage after that
      if (i == 0) begin : g_first
         assign rem_s = num[QUO_W+DEN_W-1:QUO_W];
         assign lo_s  = num[QUO_W-1:0];
         assign den_s = den;
         assign quo_s = '0;
      end else begin : g_next
         assign rem_s = rem_ff[i-1];
         assign lo_s  = lo_ff[i-1];
         assign den_s = den_ff[i-1];
         assign quo_s = quo_ff[i-1];
      end

      // bring down one numerator bit, trial subtract
      assign trial = {rem_s, lo_s[QUO_W-1-i]};
      assign ge    = trial >= {1'b0, den_s};

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[i] <= {quo_s[QUO_W-2:0], ge};
         end
      end

      if (i < QUO_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= ge ? DEN_W'(trial - {1'b0, den_s}) : trial[DEN_W-1:0];
               lo_ff[i]  <= lo_s;
               den_ff[i] <= den_s;
            end
         end
      end
   end

   assign quot = quo_ff[QUO_W-1];

endmodule

// File: src/svpt_front.sv
// Front stages: sector test, active-vector expressions, products, divider operands.
module svpt_front import svpt_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     valid_in,
   input  logic signed [VOLT_W-1:0] alpha,
   input  logic signed [VOLT_W-1:0] beta,
   input  logic        [VOLT_W-1:0] bus,
   input  logic        [CNT_W-1:0]  period,
   output logic                     valid_out,
   output svpt_tag_type             tag_out,
   output logic [NUM1_W-1:0]        num_x,
   output logic [NUM1_W-1:0]        num_y,
   output logic [NUM3_W-1:0]        num_r,
   output logic [VOLT_W-1:0]        den_bus,
   output logic [DEN3_W-1:0]        den_sum
);

   // stage 1: projections and sign tests
   logic signed [E_W-1:0] a_s, b_s, x_in, y_in, z_in, tb_in, tc_in;
   logic signed [E_W-1:0] x_ff, y_ff, z_ff;
   sector_type            code_in, code1_ff, code2_ff, code3_ff;
   logic [VOLT_W-1:0]     u_in, u1_ff, u2_ff, u3_ff;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;

   assign a_s   = {{(E_W-VOLT_W){alpha[VOLT_W-1]}}, alpha};
   assign b_s   = {{(E_W-VOLT_W){beta[VOLT_W-1]}}, beta};
   assign x_in  = K_SQRT3 * b_s;
   assign y_in  = K_1P5 * a_s + K_0P866 * b_s;
   assign z_in  = K_0P866 * b_s - K_1P5 * a_s;
   assign tb_in = K_SQRT3 * a_s - (b_s <<< FRAC_W);
   assign tc_in = -(K_SQRT3 * a_s) - (b_s <<< FRAC_W);
   assign code_in = {(!tc_in[E_W-1] && tc_in != '0),
                     (!tb_in[E_W-1] && tb_in != '0),
                     (!b_s[E_W-1] && b_s != '0)};
   assign u_in  = (bus == '0) ? VOLT_W'(1) : bus;

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         code1_ff <= code_in;
         u1_ff    <= u_in;
      end
   end

   // stage 2: pick the sector's pair and clamp negatives to zero
   logic signed [E_W-1:0] ex, ey;
   logic [CX_W-1:0]       cx_in, cy_in, cx_ff, cy_ff;

   always_comb begin
      unique case (code1_ff)
         SECTOR_1: begin ex = z_ff;  ey = y_ff;  end
         SECTOR_2: begin ex = y_ff;  ey = -x_ff; end
         SECTOR_3: begin ex = -z_ff; ey = x_ff;  end
         SECTOR_4: begin ex = -x_ff; ey = z_ff;  end
         SECTOR_5: begin ex = x_ff;  ey = -y_ff; end
         SECTOR_6: begin ex = -y_ff; ey = -z_ff; end
         default:  begin ex = '0;    ey = '0;    end
      endcase
   end

   assign cx_in = ex[E_W-1] ? '0 : ex[CX_W-1:0];
   assign cy_in = ey[E_W-1] ? '0 : ey[CX_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         code2_ff <= code1_ff;
         u2_ff    <= u1_ff;
      end
   end

   // stage 3: scale by the period
   logic [N_W-1:0]    nx_ff, ny_ff;
   logic [DEN3_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nx_ff    <= N_W'(cx_ff) * N_W'(period);
         ny_ff    <= N_W'(cy_ff) * N_W'(period);
         sum_ff   <= DEN3_W'(cx_ff) + DEN3_W'(cy_ff);
         code3_ff <= code2_ff;
         u3_ff    <= u2_ff;
      end
   end

   // stage 4: quotient overflow checks and divider operands
   logic ovf_x_in, ovf_y_in;

   assign ovf_x_in = nx_ff >= (N_W'(u3_ff) << (Q_W - FRAC_W));
   assign ovf_y_in = ny_ff >= (N_W'(u3_ff) << (Q_W - FRAC_W));

   always_ff @(posedge clock) begin
      if (en) begin
         num_x    <= ovf_x_in ? '0 : {nx_ff[NUM1_W-FRAC_W-1:0], FRAC_W'(0)};
         num_y    <= ovf_y_in ? '0 : {ny_ff[NUM1_W-FRAC_W-1:0], FRAC_W'(0)};
         num_r    <= NUM3_W'({nx_ff, (Q_W - FRAC_W)'(0)});
         den_bus  <= u3_ff;
         den_sum  <= sum_ff;
         tag_out  <= '{code: code3_ff, ovf_x: ovf_x_in, ovf_y: ovf_y_in,
                       den_zero: (sum_ff == '0)};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign valid_out = v4_ff;

endmodule

// File: src/svpt_back.sv
// Back stages: overmodulation rescale, phase times, count rounding, output register.
module svpt_back import svpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             valid_in,
   input  svpt_tag_type     tag_in,
   input  logic [Q_W-1:0]   quo_x,
   input  logic [Q_W-1:0]   quo_y,
   input  logic [Q_W-1:0]   quo_r,
   input  logic [CNT_W-1:0] period,
   output logic             valid_out,
   output logic [OUT_W-1:0] count_a,
   output logic [OUT_W-1:0] count_b,
   output logic [OUT_W-1:0] count_c,
   output sector_type       code_out
);

   // round half up to a whole count, saturate
   function automatic logic [OUT_W-1:0] to_count(input logic [T_W-1:0] t);
      logic [T_W:0]       s;
      logic [T_W-FRAC_W:0] c;
      s = (T_W+1)'(t) + (T_W+1)'(32768);
      c = s[T_W:FRAC_W];
      return (c > (T_W-FRAC_W+1)'(32767)) ? '1 : c[OUT_W-1:0];
   endfunction

   logic [T_W-1:0] p16;
   assign p16 = {period, FRAC_W'(0)};

   // stage A: saturate, overmodulation test and rescale
   logic [Q_W:0]   tx_full, ty_full;
   logic [Q_W+1:0] tsum;
   logic           over;
   logic [T_W-1:0] tr, tx_in, ty_in, tx_ff, ty_ff;
   sector_type     code_a_ff;
   logic           va_ff, vo_ff;

   assign tx_full = tag_in.ovf_x ? ((Q_W+1)'(1) << Q_W) : {1'b0, quo_x};
   assign ty_full = tag_in.ovf_y ? ((Q_W+1)'(1) << Q_W) : {1'b0, quo_y};
   assign tsum    = (Q_W+2)'(tx_full) + (Q_W+2)'(ty_full);
   assign over    = (tsum > (Q_W+2)'(p16)) && !tag_in.den_zero;
   assign tr      = quo_r[Q_W-1:Q_W-T_W];
   assign tx_in   = over ? tr : tx_full[T_W-1:0];
   assign ty_in   = over ? (p16 - tr) : ty_full[T_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
         code_a_ff <= tag_in.code;
      end
   end

   // stage B: half-zero time, phase ordering by sector
   logic [T_W-1:0]   ta, tb, tc;
   logic [OUT_W-1:0] ca, cb, cc, cq;
   logic [OUT_W-1:0] a_in, b_in, c_in;

   assign ta = (p16 - tx_ff - ty_ff) >> 2;
   assign tb = ta + (tx_ff >> 1);
   assign tc = tb + (ty_ff >> 1);
   assign ca = to_count(ta);
   assign cb = to_count(tb);
   assign cc = to_count(tc);
   assign cq = to_count(p16 >> 2);

   always_comb begin
      unique case (code_a_ff)
         SECTOR_1: begin a_in = cb; b_in = ca; c_in = cc; end
         SECTOR_2: begin a_in = ca; b_in = cc; c_in = cb; end
         SECTOR_3: begin a_in = ca; b_in = cb; c_in = cc; end
         SECTOR_4: begin a_in = cc; b_in = cb; c_in = ca; end
         SECTOR_5: begin a_in = cc; b_in = ca; c_in = cb; end
         SECTOR_6: begin a_in = cb; b_in = cc; c_in = ca; end
         default:  begin a_in = cq; b_in = cq; c_in = cq; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         count_a  <= a_in;
         count_b  <= b_in;
         count_c  <= c_in;
         code_out <= code_a_ff;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         va_ff <= valid_in;
         vo_ff <= va_ff;
      end
   end

   assign valid_out = vo_ff;

endmodule

// File: src/space_vector_pwm_timing_top.sv
// Path: a request beat passes the front stages, the divider pipes and the back stages to its response beat.
// Throughput: one beat per cycle while responses are taken; the 40-stage divider pipes set the depth.
// The whole pipeline advances together; it holds while a response waits unread.
// Reset (synchronous, active high) clears all valid bits and sets the period to 1000.
// Top level: period register, front stages, three divider pipes, back stages.
module space_vector_pwm_timing_top import svpt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data,
   svpt_req_if.sink         req,
   svpt_rsp_if.source       rsp
);

   logic en;
   logic out_valid;

   // period register
   logic [CNT_W-1:0] period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   // pipeline advances when the output slot is free or being taken
   assign en        = !out_valid || rsp.ready;
   assign req.ready = en;

   // front stages
   logic              f_valid;
   svpt_tag_type      f_tag;
   logic [NUM1_W-1:0] num_x, num_y;
   logic [NUM3_W-1:0] num_r;
   logic [VOLT_W-1:0] den_bus;
   logic [DEN3_W-1:0] den_sum;

   svpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req.valid),
      .alpha     (req.alpha_voltage),
      .beta      (req.beta_voltage),
      .bus       (req.bus_voltage),
      .period    (period_ff),
      .valid_out (f_valid),
      .tag_out   (f_tag),
      .num_x     (num_x),
      .num_y     (num_y),
      .num_r     (num_r),
      .den_bus   (den_bus),
      .den_sum   (den_sum)
   );

   // dividers: both active times over the bus, rescale over the sum
   logic [Q_W-1:0] quo_x, quo_y, quo_r;

   svpt_div_pipe #(.DEN_W(VOLT_W), .QUO_W(Q_W)) u_div_x (
      .clock (clock), .en (en), .num (num_x), .den (den_bus), .quot (quo_x)
   );

   svpt_div_pipe #(.DEN_W(VOLT_W), .QUO_W(Q_W)) u_div_y (
      .clock (clock), .en (en), .num (num_y), .den (den_bus), .quot (quo_y)
   );

   svpt_div_pipe #(.DEN_W(DEN3_W), .QUO_W(Q_W)) u_div_r (
      .clock (clock), .en (en), .num (num_r), .den (den_sum), .quot (quo_r)
   );

   // valid bits and side data matched to the divider depth
   svpt_tag_type tag_ff [Q_W];
   logic         vld_ff [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_tag
      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[i] <= (i == 0) ? f_tag : tag_ff[(i == 0) ? 0 : i - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= (i == 0) ? f_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end
      end
   end

   // back stages and output register
   svpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (vld_ff[Q_W-1]),
      .tag_in    (tag_ff[Q_W-1]),
      .quo_x     (quo_x),
      .quo_y     (quo_y),
      .quo_r     (quo_r),
      .period    (period_ff),
      .valid_out (out_valid),
      .count_a   (rsp.phase_a_count),
      .count_b   (rsp.phase_b_count),
      .count_c   (rsp.phase_c_count),
      .code_out  (rsp.sector_code)
   );

   assign rsp.valid = out_valid;

endmodule

// File: bench/space_vector_pwm_timing_top_tb.sv
// Self-checking testbench for the space vector PWM timing block.
module space_vector_pwm_timing_top_tb import svpt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PHASE_ITEMS  = 272;

   typedef struct {
      logic [OUT_W-1:0] count_a;
      logic [OUT_W-1:0] count_b;
      logic [OUT_W-1:0] count_c;
      sector_type       sector;
   } compare_set_type;

   // Scoreboard: own copy of the period register and the queue of expected compare sets
   class timing_book;
      longint unsigned period;
      compare_set_type awaited[$];
      int              mismatches;

      function new();
         period     = longint'(PERIOD_RESET);
         mismatches = 0;
      endfunction

      // floor(e * p / d) in Q16.16, capped at 2^40
      function longint unsigned scaled_time(longint unsigned e, longint unsigned p,
                                            longint unsigned d);
         longint unsigned n, q, r;
         n = e * p;
         q = n / d;
         r = n % d;
         if (q >= (64'd1 << 24))
            return 64'd1 << 40;
         return (q << 16) + ((r << 16) / d);
      endfunction

      function logic [OUT_W-1:0] rounded_count(longint unsigned t);
         longint unsigned c;
         c = (t + 64'd32768) >> 16;
         return (c > 64'd32767) ? 15'h7FFF : c[OUT_W-1:0];
      endfunction

      function compare_set_type switching_times(logic signed [VOLT_W-1:0] a_in,
                                                logic signed [VOLT_W-1:0] b_in,
                                                logic [VOLT_W-1:0] u_in);
         compare_set_type res;
         longint          a, b, x, y, z, ex, ey;
         longint unsigned u, p16, cx, cy, tx, ty, ta, tb, tc, o0, o1, o2;
         sector_type      code;
         a    = longint'(a_in);
         b    = longint'(b_in);
         u    = (u_in == 0) ? 64'd1 : longint'(u_in);
         p16  = period << 16;
         code = SECTOR_ZERO;
         if (b > 0)
            code = code + 3'd1;
         if (113512 * a - 65536 * b > 0)
            code = code + 3'd2;
         if (-113512 * a - 65536 * b > 0)
            code = code + 3'd4;
         x = 113512 * b;
         y = 98304 * a + 56756 * b;
         z = -98304 * a + 56756 * b;
         case (code)
            SECTOR_1: begin ex = z;  ey = y;  end
            SECTOR_2: begin ex = y;  ey = -x; end
            SECTOR_3: begin ex = -z; ey = x;  end
            SECTOR_4: begin ex = -x; ey = z;  end
            SECTOR_5: begin ex = x;  ey = -y; end
            SECTOR_6: begin ex = -y; ey = -z; end
            default: begin ex = 0; ey = 0; end
         endcase
         res.sector = code;
         if (code == SECTOR_ZERO || code == 3'd7) begin
            res.count_a = rounded_count(p16 >> 2);
            res.count_b = res.count_a;
            res.count_c = res.count_a;
            return res;
         end
         // negative active times clamp to zero
         cx = (ex < 0) ? 64'd0 : ex;
         cy = (ey < 0) ? 64'd0 : ey;
         tx = scaled_time(cx, period, u);
         ty = scaled_time(cy, period, u);
         // overmodulation: share the whole period in proportion
         if (tx + ty > p16 && cx + cy > 0) begin
            tx = scaled_time(cx, period, cx + cy);
            if (tx > p16)
               tx = p16;
            ty = p16 - tx;
         end
         ta = (p16 - tx - ty) >> 2;
         tb = ta + (tx >> 1);
         tc = tb + (ty >> 1);
         case (code)
            SECTOR_1: begin o0 = tb; o1 = ta; o2 = tc; end
            SECTOR_2: begin o0 = ta; o1 = tc; o2 = tb; end
            SECTOR_3: begin o0 = ta; o1 = tb; o2 = tc; end
            SECTOR_4: begin o0 = tc; o1 = tb; o2 = ta; end
            SECTOR_5: begin o0 = tc; o1 = ta; o2 = tb; end
            default: begin o0 = tb; o1 = tc; o2 = ta; end
         endcase
         res.count_a = rounded_count(o0);
         res.count_b = rounded_count(o1);
         res.count_c = rounded_count(o2);
         return res;
      endfunction

      function void note_vector(logic signed [VOLT_W-1:0] a, logic signed [VOLT_W-1:0] b,
                                logic [VOLT_W-1:0] u);
         awaited.push_back(switching_times(a, b, u));
      endfunction

      function void check_counts(compare_set_type got);
         compare_set_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: a=%0d b=%0d c=%0d sector=%0d",
                        got.count_a, got.count_b, got.count_c, got.sector);
            return;
         end
         want = awaited.pop_front();
         if (got.count_a !== want.count_a || got.count_b !== want.count_b ||
             got.count_c !== want.count_c || got.sector !== want.sector) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected a=%0d b=%0d c=%0d sector=%0d, got a=%0d b=%0d c=%0d sector=%0d",
                        want.count_a, want.count_b, want.count_c, want.sector,
                        got.count_a, got.count_b, got.count_c, got.sector);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;
   bit               calm;
   bit               hold_off;
   int               quiet_cycles;
   timing_book       book;

   svpt_req_if req_bus ();
   svpt_rsp_if rsp_bus ();

   space_vector_pwm_timing_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_bus),
      .rsp         (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Response side: random back-pressure, one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
      end
   end

   // Check each response beat; watchdog on cycles without any beat
   always @(posedge clock) begin
      compare_set_type got;
      if (rsp_bus.valid && rsp_bus.ready && !reset) begin
         got.count_a = rsp_bus.phase_a_count;
         got.count_b = rsp_bus.phase_b_count;
         got.count_c = rsp_bus.phase_c_count;
         got.sector  = rsp_bus.sector_code;
         book.check_counts(got);
      end
      if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // One request beat, with an optional idle gap first; called at a falling edge
   task automatic drive_vector(logic signed [VOLT_W-1:0] a, logic signed [VOLT_W-1:0] b,
                               logic [VOLT_W-1:0] u);
      int gap;
      gap = (!calm && $urandom_range(99) < 35) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.alpha_voltage <= a;
      req_bus.beta_voltage  <= b;
      req_bus.bus_voltage   <= u;
      do @(posedge clock); while (!req_bus.ready);
      book.note_vector(a, b, u);
      @(negedge clock);
   endtask

   // Period write once the pipe has drained
   task automatic set_period(logic [CNT_W-1:0] p);
      req_bus.valid <= 1'b0;
      while (book.awaited.size() != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      book.period = longint'(p);
   endtask

   // Mostly in-range vectors against the bus, some over the hexagon, some raw noise
   task automatic random_vector();
      int u, a, b, pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         drive_vector(VOLT_W'($urandom), VOLT_W'($urandom), VOLT_W'($urandom));
      end else begin
         u = (pick < 25) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
         if (pick < 75) begin
            a = $urandom_range(0, u) - u / 2;
            b = $urandom_range(0, u) - u / 2;
         end else begin
            a = $urandom_range(0, 2 * u) - u;
            b = $urandom_range(0, 2 * u) - u;
         end
         if (a > 32767) a = 32767;
         if (a < -32768) a = -32768;
         if (b > 32767) b = 32767;
         if (b < -32768) b = -32768;
         drive_vector(VOLT_W'(a), VOLT_W'(b), VOLT_W'(u));
      end
   endtask

   initial begin
      logic [CNT_W-1:0] periods [6];
      book          = new();
      calm          = 1'b0;
      hold_off      = 1'b0;
      quiet_cycles  = 0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid = 1'b0;
      req_bus.alpha_voltage = '0;
      req_bus.beta_voltage  = '0;
      req_bus.bus_voltage   = 16'd1;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero vector, field extremes, each sector, overmodulation, zero bus
      drive_vector(0, 0, 100);
      drive_vector(0, 0, 0);
      drive_vector(-32768, -32768, 65535);
      drive_vector(32767, 32767, 65535);
      drive_vector(32767, -32768, 1);
      drive_vector(-32768, 32767, 1);
      drive_vector(100, 50, 400);
      drive_vector(0, 100, 400);
      drive_vector(-100, 50, 400);
      drive_vector(-100, -50, 400);
      drive_vector(0, -100, 400);
      drive_vector(100, -50, 400);
      drive_vector(30000, 1000, 100);
      drive_vector(-20000, -20000, 0);
      drive_vector(1, 0, 65535);
      drive_vector(-1, 0, 65535);
      drive_vector(0, 1, 1);
      drive_vector(0, -1, 1);
      set_period(16'hFFFF);
      drive_vector(0, 0, 5);
      drive_vector(32767, 0, 1);
      drive_vector(10, 5, 60000);
      drive_vector(-5, -5, 20);
      set_period(16'd1);
      drive_vector(0, 0, 9);
      drive_vector(-300, 200, 1000);

      periods = '{16'd1000, 16'hFFFF, 16'd37, 16'd1, 16'd0, 16'd4096};
      periods[4] = CNT_W'($urandom_range(1, 65535));
      for (int ph = 0; ph < 6; ph++) begin
         set_period(periods[ph]);
         calm = (ph == 2);
         if (ph == 1)
            hold_off = 1'b1;
         repeat (PHASE_ITEMS) random_vector();
      end

      req_bus.valid <= 1'b0;
      while (book.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
